FILE: rtl/core/tlss_pkg.sv
// ----------------------------------------------------------------------------
// tlss_pkg
// shared constants and types of the two-layer spread sketch update
// ----------------------------------------------------------------------------
package tlss_pkg;

   localparam int BITMAP_BITS = 8;
   localparam int NUM_BITMAPS = 4096;
   localparam int HLL_REGS    = 16;
   localparam int NUM_HLLS    = 1024;
   localparam int TABLE_SIZE  = 1024;

   localparam int BM_AW   = $clog2(NUM_BITMAPS);
   localparam int HLL_AW  = $clog2(NUM_HLLS);
   localparam int BKT_W   = $clog2(HLL_REGS);
   localparam int REG_AW  = HLL_AW + BKT_W;
   localparam int TBL_AW  = $clog2(TABLE_SIZE);
   localparam int SUM_W   = $clog2(HLL_REGS * 15 + 1);
   localparam int BIT_W   = $clog2(BITMAP_BITS);
   localparam int RANK_W  = 4;
   localparam logic [RANK_W-1:0] RANK_CAP = 4'd15;
   localparam int QDEPTH  = 4;
   localparam int QAW     = $clog2(QDEPTH);

   // clearing pass of the layer-2 stores covers the larger of sketches and slots
   localparam int L2_CLR_N  = (NUM_HLLS > TABLE_SIZE) ? NUM_HLLS : TABLE_SIZE;
   localparam int L2_CLR_AW = $clog2(L2_CLR_N);

   // item handed from front to back
   typedef struct packed {
      logic [63:0] flow_hash_a;
      logic [63:0] flow_hash_b;
      logic [63:0] elem_hash;
      logic [63:0] flow_key;
   } item_type;

   typedef struct packed {
      logic went_to_layer2;
      logic register_raised;
      logic table_written;
   } result_type;

endpackage

FILE: rtl/core/tlss_layer1.sv
// ----------------------------------------------------------------------------
// tlss_layer1
// layer-1 bitmap test and update; one item at a time (read, then write)
// ----------------------------------------------------------------------------
module tlss_layer1 (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tlss_pkg::item_type  in_item,
   output logic                out_valid,
   output logic                out_l2,
   output tlss_pkg::item_type  out_item,
   input  logic                out_ready
);
   import tlss_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_READ  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   localparam logic [BITMAP_BITS-1:0] FULL = '1;

   logic [BITMAP_BITS-1:0] mem [NUM_BITMAPS];
   logic [BM_AW-1:0] clr_ff;
   logic [BITMAP_BITS-1:0] rd0_ff, rd1_ff;
   state_type state_ff, state_in;
   item_type item_ff;
   logic out_valid_ff, out_l2_ff;
   item_type out_item_ff;
   logic [BM_AW-1:0] a0, a1, pa, pb;
   logic pick;

   assign pick = item_ff.elem_hash[48];
   assign a0 = BM_AW'(item_ff.flow_hash_a[63:32] % NUM_BITMAPS);
   assign a1 = BM_AW'(item_ff.flow_hash_a[31:0] % NUM_BITMAPS);
   assign pa = pick ? a1 : a0;
   assign pb = pick ? a0 : a1;

   logic [BM_AW-1:0] ra0, ra1;
   assign ra0 = BM_AW'(in_item.flow_hash_a[63:32] % NUM_BITMAPS);
   assign ra1 = BM_AW'(in_item.flow_hash_a[31:0] % NUM_BITMAPS);

   // single-zero fill test
   function automatic logic [BITMAP_BITS:0] full_fill(input logic [BITMAP_BITS-1:0] bm);
      logic [BIT_W:0] zeros;
      logic [BITMAP_BITS-1:0] res;
      zeros = '0;
      res = bm;
      for (int i = 0; i < BITMAP_BITS; i++) begin
         if (!bm[i]) begin
            zeros = zeros + 1'b1;
         end
      end
      if (zeros <= 1) begin
         res = FULL;
      end
      return {zeros <= 1, res};
   endfunction

   logic [BITMAP_BITS-1:0] bma, bmb, wa, wb;
   logic fa, fb, wr_a, wr_b;
   logic [BIT_W-1:0] ebit;
   always_comb begin
      bma = pick ? rd1_ff : rd0_ff;
      bmb = pick ? rd0_ff : rd1_ff;
      {fa, wa} = full_fill(bma);
      ebit = BIT_W'(item_ff.elem_hash[47:32] % BITMAP_BITS);
      if (!fa) begin
         wa = bma | (BITMAP_BITS'(1) << ebit);
      end
      wr_a = 1'b1;
      // second bitmap sees first bitmap's write when both are the same entry
      if (pa == pb) begin
         bmb = wa;
      end
      {fb, wb} = full_fill(bmb);
      wr_b = fa;
   end

   logic can_out;
   assign can_out = !out_valid_ff || out_ready;
   assign in_ready = (state_ff == ST_READ);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == BM_AW'(NUM_BITMAPS - 1)) state_in = ST_READ;
         ST_READ:  if (in_valid) state_in = ST_WRITE;
         ST_WRITE: if (can_out) state_in = ST_READ;
         default:  state_in = ST_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_WRITE && can_out) begin
            out_valid_ff <= 1'b1;
            out_l2_ff <= fa && fb;
            out_item_ff <= item_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      // clearing pass after reset, one bitmap per cycle
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff] <= '0;
      end
      if (state_ff == ST_READ && in_valid) begin
         item_ff <= in_item;
         rd0_ff <= mem[ra0];
         rd1_ff <= mem[ra1];
      end
      if (state_ff == ST_WRITE && can_out) begin
         if (wr_b) begin
            mem[pb] <= wb;
         end
         if (wr_a && !(wr_b && pa == pb)) begin
            mem[pa] <= wa;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_l2 = out_l2_ff;
   assign out_item = out_item_ff;

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("layer1 state not one-hot");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == ST_WRITE)
      else $error("layer1 accept did not advance");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("layer1 output dropped");
`endif
endmodule

FILE: rtl/core/tlss_queue.sv
// ----------------------------------------------------------------------------
// tlss_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module tlss_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_l2,
   input  tlss_pkg::item_type  in_item,
   output logic                out_valid,
   output logic                out_l2,
   output tlss_pkg::item_type  out_item,
   input  logic                out_ready
);
   import tlss_pkg::*;

   item_type q_item [QDEPTH];
   logic [QDEPTH-1:0] q_l2;
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0] cnt_ff;
   logic wr, rd;

   assign in_ready = cnt_ff != (QAW+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_item = q_item[rp_ff];
   assign out_l2 = q_l2[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAW+1)'(wr) - (QAW+1)'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         q_item[wp_ff] <= in_item;
         q_l2[wp_ff] <= in_l2;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QAW+1)'(QDEPTH))
      else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wp_ff == rp_ff))
      else $error("queue pointers disagree");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count slip");
`endif
endmodule

FILE: rtl/core/tlss_layer2.sv
// ----------------------------------------------------------------------------
// tlss_layer2
// hyperloglog register raise, sketch sums and two-choice table insert
// ----------------------------------------------------------------------------
module tlss_layer2 (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_l2,
   input  tlss_pkg::item_type    in_item,
   output logic                  out_valid,
   output tlss_pkg::result_type  out_res,
   input  logic                  out_ready
);
   import tlss_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_READ  = 4'b0010,
      ST_RAISE = 4'b0100,
      ST_TABLE = 4'b1000
   } state_type;

   // one word holds all registers of a sketch
   logic [HLL_REGS*RANK_W-1:0] regs [NUM_HLLS];
   logic [SUM_W-1:0] sums [NUM_HLLS];
   logic [63:0] skey [TABLE_SIZE];
   logic [SUM_W-1:0] ssum [TABLE_SIZE];
   logic svalid [TABLE_SIZE];

   logic [L2_CLR_AW-1:0] clr_ff;
   state_type state_ff, state_in;
   item_type item_ff;
   logic l2_ff;
   logic [HLL_REGS*RANK_W-1:0] rword_ff;
   logic [SUM_W-1:0] s1_ff, s2_ff;
   logic [63:0] k1_ff, k2_ff;
   logic [SUM_W-1:0] ts1_ff, ts2_ff;
   logic tv1_ff, tv2_ff;
   logic [SUM_W-1:0] m_ff;
   logic out_valid_ff;
   result_type res_ff;

   logic [HLL_AW-1:0] ip1, ip2, upd;
   logic [BKT_W-1:0] bkt;
   logic [RANK_W-1:0] rank, cur;
   logic [HLL_REGS*RANK_W-1:0] nword;
   logic [5:0] lz;
   logic [TBL_AW-1:0] t1, t2;

   function automatic logic [5:0] clz32(input logic [31:0] x);
      logic [5:0] n;
      logic done;
      n = 6'd32;
      done = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (x[i] && !done) begin
            n = 6'(31 - i);
            done = 1'b1;
         end
      end
      return n;
   endfunction

   // decode for the held item
   always_comb begin
      ip1 = HLL_AW'(item_ff.flow_hash_b[63:32] % NUM_HLLS);
      ip2 = HLL_AW'(item_ff.flow_hash_b[31:0] % NUM_HLLS);
      upd = item_ff.elem_hash[63] ? ip1 : ip2;
      bkt = item_ff.elem_hash[BKT_W-1:0];
      lz = clz32(item_ff.elem_hash[31:0]);
      rank = (lz >= 6'd14) ? RANK_CAP : RANK_W'(lz + 6'd1);
      cur = rword_ff[bkt*RANK_W +: RANK_W];
      nword = rword_ff;
      nword[bkt*RANK_W +: RANK_W] = rank;
      t1 = TBL_AW'(item_ff.flow_hash_a[63:48] % TABLE_SIZE);
      t2 = TBL_AW'(item_ff.flow_hash_a[47:32] % TABLE_SIZE);
   end

   logic [HLL_AW-1:0] np1, np2, nupd;
   logic [TBL_AW-1:0] nt1, nt2;
   always_comb begin
      np1 = HLL_AW'(in_item.flow_hash_b[63:32] % NUM_HLLS);
      np2 = HLL_AW'(in_item.flow_hash_b[31:0] % NUM_HLLS);
      nupd = in_item.elem_hash[63] ? np1 : np2;
      nt1 = TBL_AW'(in_item.flow_hash_a[63:48] % TABLE_SIZE);
      nt2 = TBL_AW'(in_item.flow_hash_a[47:32] % TABLE_SIZE);
   end

   logic raised;
   logic [SUM_W-1:0] nsum, ns1, ns2, msum;
   always_comb begin
      raised = l2_ff && (cur < rank);
      nsum = (item_ff.elem_hash[63] ? s1_ff : s2_ff) + SUM_W'(rank - cur);
      ns1 = (upd == ip1) ? nsum : s1_ff;
      ns2 = (upd == ip2) ? nsum : s2_ff;
      msum = (ns1 < ns2) ? ns1 : ns2;
   end

   logic w1, w2, wr;
   always_comb begin
      w1 = 1'b0;
      w2 = 1'b0;
      if (!tv1_ff || k1_ff == item_ff.flow_key) begin
         w1 = 1'b1;
      end else if (!tv2_ff || k2_ff == item_ff.flow_key) begin
         w2 = 1'b1;
      end else if (ts1_ff > ts2_ff) begin
         w2 = m_ff >= ts2_ff;
      end else begin
         w1 = m_ff >= ts1_ff;
      end
      wr = w1 || w2;
   end

   logic can_out;
   assign can_out = !out_valid_ff || out_ready;
   assign in_ready = (state_ff == ST_READ);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == L2_CLR_AW'(L2_CLR_N - 1)) state_in = ST_READ;
         ST_READ:  if (in_valid) state_in = ST_RAISE;
         ST_RAISE: if (raised) state_in = ST_TABLE;
                   else if (can_out) state_in = ST_READ;
         ST_TABLE: if (can_out) state_in = ST_READ;
         default:  state_in = ST_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         if (state_ff == ST_RAISE && !raised && can_out) begin
            out_valid_ff <= 1'b1;
            res_ff <= '{went_to_layer2: l2_ff, register_raised: 1'b0, table_written: 1'b0};
         end
         if (state_ff == ST_TABLE && can_out) begin
            out_valid_ff <= 1'b1;
            res_ff <= '{went_to_layer2: 1'b1, register_raised: 1'b1, table_written: wr};
         end
      end
   end

   always_ff @(posedge clock) begin
      // clearing pass after reset, one sketch and one slot per cycle
      if (state_ff == ST_CLEAR) begin
         regs[clr_ff[HLL_AW-1:0]] <= '0;
         sums[clr_ff[HLL_AW-1:0]] <= '0;
         svalid[clr_ff[TBL_AW-1:0]] <= 1'b0;
      end
      if (state_ff == ST_READ && in_valid) begin
         item_ff <= in_item;
         l2_ff <= in_l2;
         rword_ff <= regs[nupd];
         s1_ff <= sums[np1];
         s2_ff <= sums[np2];
         k1_ff <= skey[nt1];
         k2_ff <= skey[nt2];
         ts1_ff <= ssum[nt1];
         ts2_ff <= ssum[nt2];
         tv1_ff <= svalid[nt1];
         tv2_ff <= svalid[nt2];
      end
      if (state_ff == ST_RAISE && raised) begin
         regs[upd] <= nword;
         sums[upd] <= nsum;
         m_ff <= msum;
      end
      if (state_ff == ST_TABLE && can_out) begin
         if (w1) begin
            skey[t1] <= item_ff.flow_key;
            ssum[t1] <= m_ff;
            svalid[t1] <= 1'b1;
         end
         if (w2) begin
            skey[t2] <= item_ff.flow_key;
            ssum[t2] <= m_ff;
            svalid[t2] <= 1'b1;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res = res_ff;

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("layer2 state not one-hot");
   a_chain: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (!out_res.table_written || out_res.register_raised)
                 && (!out_res.register_raised || out_res.went_to_layer2))
      else $error("result flags inconsistent");
   a_onewr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TABLE) |-> !(w1 && w2))
      else $error("two slots written");
`endif
endmodule

FILE: rtl/core/two_layer_spread_sketch_update.sv
// ----------------------------------------------------------------------------
// two_layer_spread_sketch_update
// per-packet update of a two-layer bitmap / hyperloglog spread sketch
// ----------------------------------------------------------------------------
// channel   ports                                  handshake
// req       flow_hash_a, flow_hash_b, elem_hash,   push / full
//           flow_key
// rsp       went_to_layer2, register_raised,       pop / empty
//           table_written
//
// the front (layer 1) takes one transaction at a time: bitmap read, then
// test and write back; a 4-entry queue decouples it from the back
// the back (layer 2) takes one transaction at a time: register read, raise,
// then table insert when a register is raised; one write per store per item
// reset is synchronous; then the front clears its 4096 bitmaps with full
// held high, while the back clears its 1024 sketches and table slots
// a stalled rsp side backs up the queue, then raises full
// ----------------------------------------------------------------------------
module two_layer_spread_sketch_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_flow_hash_a,
   input  logic [63:0] req_flow_hash_b,
   input  logic [63:0] req_elem_hash,
   input  logic [63:0] req_flow_key,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_went_to_layer2,
   output logic        rsp_register_raised,
   output logic        rsp_table_written
);
   import tlss_pkg::*;

   item_type req_item, f_item, q_item;
   logic f_valid, f_ready, f_l2, f_rdy_in;
   logic q_valid, q_ready, q_l2;
   logic b_valid;
   result_type b_res;

   assign req_item = '{flow_hash_a: req_flow_hash_a, flow_hash_b: req_flow_hash_b,
                       elem_hash: req_elem_hash, flow_key: req_flow_key};

   // front: layer-1 classification
   tlss_layer1 u_front (
      .clock, .reset,
      .in_valid(push), .in_ready(f_rdy_in), .in_item(req_item),
      .out_valid(f_valid), .out_l2(f_l2), .out_item(f_item), .out_ready(f_ready)
   );
   assign full = !f_rdy_in;

   tlss_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_l2(f_l2), .in_item(f_item),
      .out_valid(q_valid), .out_l2(q_l2), .out_item(q_item), .out_ready(q_ready)
   );

   // back: layer 2, every transaction passes through for ordering
   tlss_layer2 u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_l2(q_l2), .in_item(q_item),
      .out_valid(b_valid), .out_res(b_res), .out_ready(pop)
   );

   assign empty = !b_valid;
   assign rsp_went_to_layer2 = b_res.went_to_layer2;
   assign rsp_register_raised = b_res.register_raised;
   assign rsp_table_written = b_res.table_written;

`ifndef NO_ASSERTIONS
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_table_written))
      else $error("result changed while stalled");
`endif
endmodule

FILE: bench/two_layer_spread_sketch_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_layer_spread_sketch_update_checker
// watches the req and rsp channels, keeps its own copy of the sketch state,
// predicts the per-packet outcome and compares it with every result
// ----------------------------------------------------------------------------
module two_layer_spread_sketch_update_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [63:0] req_flow_hash_a,
   input  logic [63:0] req_flow_hash_b,
   input  logic [63:0] req_elem_hash,
   input  logic [63:0] req_flow_key,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_went_to_layer2,
   input  logic        rsp_register_raised,
   input  logic        rsp_table_written,
   output int          error_count,
   output int          pending_count,
   output int          layer2_seen,
   output int          raised_seen,
   output int          written_seen
);
   import tlss_pkg::*;

   localparam logic [BITMAP_BITS-1:0] BM_ALL = '1;

   logic [BITMAP_BITS-1:0] bm_mirror [NUM_BITMAPS];
   logic [RANK_W-1:0]      rank_mirror [NUM_HLLS*HLL_REGS];
   int unsigned            sum_mirror [NUM_HLLS];
   bit                     slot_used [TABLE_SIZE];
   logic [63:0]            slot_owner [TABLE_SIZE];
   int unsigned            slot_weight [TABLE_SIZE];
   result_type             outcome_q [$];

   // full test; fills a single remaining zero
   function automatic bit bitmap_full(int unsigned pos);
      int zeros;
      int last;
      zeros = 0;
      last = 0;
      if (bm_mirror[pos] == BM_ALL) return 1;
      for (int i = 0; i < BITMAP_BITS; i++)
         if (!bm_mirror[pos][i]) begin
            zeros++;
            last = i;
         end
      if (zeros > 1) return 0;
      bm_mirror[pos][last] = 1'b1;
      return 1;
   endfunction

   function automatic void claim_slot(int unsigned s, logic [63:0] key, int unsigned w);
      slot_used[s] = 1;
      slot_owner[s] = key;
      slot_weight[s] = w;
   endfunction

   function automatic bit offer_to_table(logic [63:0] key, int unsigned w, logic [63:0] ha);
      int unsigned t1;
      int unsigned t2;
      t1 = ha[63:48] % TABLE_SIZE;
      t2 = ha[47:32] % TABLE_SIZE;
      if (!slot_used[t1] || slot_owner[t1] == key) begin
         claim_slot(t1, key, w);
         return 1;
      end
      if (!slot_used[t2] || slot_owner[t2] == key) begin
         claim_slot(t2, key, w);
         return 1;
      end
      if (slot_weight[t1] > slot_weight[t2]) begin
         if (w >= slot_weight[t2]) begin
            claim_slot(t2, key, w);
            return 1;
         end
      end else if (w >= slot_weight[t1]) begin
         claim_slot(t1, key, w);
         return 1;
      end
      return 0;
   endfunction

   function automatic result_type predict_packet(logic [63:0] ha, logic [63:0] hb,
                                                 logic [63:0] he, logic [63:0] key);
      result_type r;
      int unsigned pos [2];
      int unsigned pick, s1, s2, upd, bucket, rank, cur, idx, lowest;
      logic [31:0] elo;
      r = '0;
      pos[0] = ha[63:32] % NUM_BITMAPS;
      pos[1] = ha[31:0] % NUM_BITMAPS;
      pick = he[48];
      if (!bitmap_full(pos[pick])) begin
         bm_mirror[pos[pick]][he[47:32] % BITMAP_BITS] = 1'b1;
         return r;
      end
      if (!bitmap_full(pos[pick^1])) return r;
      r.went_to_layer2 = 1;
      elo = he[31:0];
      s1 = hb[63:32] % NUM_HLLS;
      s2 = hb[31:0] % NUM_HLLS;
      bucket = elo & (HLL_REGS - 1);
      rank = 33;
      for (int i = 31; i >= 0; i--)
         if (elo[i]) begin
            rank = 32 - i;
            break;
         end
      if (rank > 15) rank = 15;
      upd = he[63] ? s1 : s2;
      idx = upd * HLL_REGS + bucket;
      cur = rank_mirror[idx];
      if (cur < rank) begin
         rank_mirror[idx] = rank;
         sum_mirror[upd] += rank - cur;
         r.register_raised = 1;
         lowest = sum_mirror[s1] < sum_mirror[s2] ? sum_mirror[s1] : sum_mirror[s2];
         r.table_written = offer_to_table(key, lowest, ha);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_BITMAPS; i++) bm_mirror[i] = '0;
         for (int i = 0; i < NUM_HLLS*HLL_REGS; i++) rank_mirror[i] = '0;
         for (int i = 0; i < NUM_HLLS; i++) sum_mirror[i] = 0;
         for (int i = 0; i < TABLE_SIZE; i++) slot_used[i] = 0;
         outcome_q.delete();
         error_count = 0;
         layer2_seen = 0;
         raised_seen = 0;
         written_seen = 0;
      end else begin
         if (push && !full)
            outcome_q.insert(outcome_q.size(),
                             predict_packet(req_flow_hash_a, req_flow_hash_b,
                                            req_elem_hash, req_flow_key));
         if (pop && !empty) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result transaction", $time);
               error_count++;
            end else begin
               want = outcome_q.pop_front();
               layer2_seen += want.went_to_layer2;
               raised_seen += want.register_raised;
               written_seen += want.table_written;
               if (rsp_went_to_layer2 !== want.went_to_layer2) begin
                  $display("%0t: went_to_layer2 expected %0d actual %0d", $time,
                           want.went_to_layer2, rsp_went_to_layer2);
                  error_count++;
               end
               if (rsp_register_raised !== want.register_raised) begin
                  $display("%0t: register_raised expected %0d actual %0d", $time,
                           want.register_raised, rsp_register_raised);
                  error_count++;
               end
               if (rsp_table_written !== want.table_written) begin
                  $display("%0t: table_written expected %0d actual %0d", $time,
                           want.table_written, rsp_table_written);
                  error_count++;
               end
            end
         end
      end
      pending_count = outcome_q.size();
   end

endmodule

FILE: bench/two_layer_spread_sketch_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_layer_spread_sketch_update_tb
// drives packets into the sketch update with random gaps and stalls; the
// checker beside the block predicts every outcome and counts mismatches
// ----------------------------------------------------------------------------
module two_layer_spread_sketch_update_tb;
   import tlss_pkg::*;

   // the clearing pass after reset alone keeps the input blocked
   localparam int WATCHDOG_LIMIT = 25000;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        pop = 0;
   logic        full, empty;
   logic [63:0] req_flow_hash_a = '0;
   logic [63:0] req_flow_hash_b = '0;
   logic [63:0] req_elem_hash = '0;
   logic [63:0] req_flow_key = '0;
   logic        rsp_went_to_layer2, rsp_register_raised, rsp_table_written;
   int          error_count, pending_count, layer2_seen, raised_seen, written_seen;

   // idle percentages per phase, and a long hold-off request for the receiver
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_rsp = 0;
   int          idle_cycles = 0;
   int          sent = 0;

   // a small pool of flows so that bitmaps fill and layer 2 gets exercised
   logic [63:0] flow_a [16];
   logic [63:0] flow_b [16];
   logic [63:0] flow_k [16];

   always #5 clock = ~clock;

   two_layer_spread_sketch_update DUT (.*);

   two_layer_spread_sketch_update_checker checker_inst (.*);

   // receiver: random stalls plus the forced hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
      end else begin
         pop <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles with no accepted transaction on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d items", sent);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // offer one packet and hold it until accepted
   task automatic send_packet(logic [63:0] ha, logic [63:0] hb,
                              logic [63:0] he, logic [63:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_flow_hash_a <= ha;
      req_flow_hash_b <= hb;
      req_elem_hash <= he;
      req_flow_key <= key;
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   task automatic go_quiet();
      push <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // packet of a pooled flow, about a quarter of them with a leading-zero-rich element word
   task automatic send_flow_packet();
      int f;
      logic [63:0] he;
      f = $urandom_range(15);
      he = rand64();
      if ($urandom_range(3) == 0) he[31:0] = he[31:0] >> $urandom_range(31);
      if ($urandom_range(50) == 0) he[31:0] = 0;
      send_packet(flow_a[f], flow_b[f], he, flow_k[f]);
   endtask

   task automatic run_random(int count);
      repeat (count) begin
         if ($urandom_range(9) < 8) send_flow_packet();
         else send_packet(rand64(), rand64(), rand64(), rand64());
      end
      go_quiet();
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         flow_a[i] = rand64();
         flow_b[i] = rand64();
         flow_k[i] = (i < 2) ? 64'd7 : rand64();  // two flows share a key
      end
      // table slots collide between flows 2 and 3
      flow_a[3][63:32] = {flow_a[2][63:48], flow_a[2][47:32] ^ 16'h0400};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, a zero element word, then fill one flow
      send_packet('0, '0, '0, '0);
      send_packet('1, '1, '1, '1);
      send_packet(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'hAAAA_AAAA_0000_0000, 64'h5555_5555_5555_5555);
      for (int i = 0; i < 20; i++)
         send_packet(64'h0000_0123_0000_0456, 64'h0000_0010_0000_0020,
                     {i[0], 14'd0, i[1], i[15:0] + 16'd1, 32'h0000_0001 << i}, 64'd99);
      go_quiet();

      // sender pauses until all expected outcomes are back
      while (pending_count != 0) @(posedge clock);

      run_random(300);
      send_idle_pct = 50;
      run_random(300);

      // long receiver hold-off while packets keep coming, so full rises
      send_idle_pct = 0;
      recv_stall_pct = 50;
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         run_random(100);
      join
      run_random(300);
      send_idle_pct = 15;
      recv_stall_pct = 15;
      run_random(350);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(300);

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d packets: %0d reached layer 2, %0d raised a register, %0d wrote the table",
               sent, layer2_seen, raised_seen, written_seen);
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
